[hw/rtl/fptcp_pkg.sv]
// Shared types, constants and helpers for the framed pan/tilt command parser.
// Used by every module under hw/rtl; depends on nothing else.
package fptcp_pkg;

  // Default frame length, including the end-of-text slot.
  localparam int unsigned MAX_FRAME_BYTES_DEF = 32;
  // Depth of the command queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register reset values.
  localparam logic [7:0] START_MARKER_RST = 8'd60;
  localparam logic [7:0] END_MARKER_RST   = 8'd62;
  localparam logic [7:0] SEPARATOR_RST    = 8'd44;
  localparam logic [15:0] PAN_RST  = 16'd140;
  localparam logic [15:0] TILT_RST = 16'd5;

  // Character codes used by the number parser.
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // Magnitude limits: the count saturates at 2^15, positive values clip at 2^15-1.
  localparam logic [15:0] MAG_SAT = 16'd32768;
  localparam logic [15:0] POS_MAX = 16'd32767;

  // Number of tokens that carry an angle.
  localparam logic [1:0] TOKENS_USED = 2'd2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_START_MARKER = 2'd0,
    CFG_END_MARKER   = 2'd1,
    CFG_SEPARATOR    = 2'd2
  } cfg_idx_t;

  // Command kinds passed from the front to the back.
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_END  = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic       cut;
  } cmd_t;

  // Phase of the token being converted.
  typedef enum logic [2:0] {
    PH_BETWEEN = 3'd0,
    PH_SPACE   = 3'd1,
    PH_SIGN    = 3'd2,
    PH_DIGITS  = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[hw/rtl/framed_pan_tilt_command_parser_unit.sv]
// A result is registered when its end command leaves the queue, behind any older commands.
// Throughput: one byte per cycle while the command queue has room; the front classifies
// a byte each cycle and the back carries out one queued command each cycle, stalling
// only while a result waits. Reset (rst_n low, synchronous): outside any frame, markers
// 60/62/44, pan 140, tilt 5, command queue and result register empty.
module framed_pan_tilt_command_parser_unit #(
  parameter int unsigned MAX_FRAME_BYTES = fptcp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pan_angle,
  output logic signed [15:0] out_tilt_angle,
  output logic               out_pan_updated,
  output logic               out_tilt_updated,
  output logic               out_truncated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);

  logic [7:0]      start_marker_r, end_marker_r, separator_r;
  logic            take, push, pop, q_empty, q_full;
  fptcp_pkg::cmd_t push_cmd, head;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= fptcp_pkg::START_MARKER_RST;
      end_marker_r   <= fptcp_pkg::END_MARKER_RST;
      separator_r    <= fptcp_pkg::SEPARATOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        fptcp_pkg::CFG_START_MARKER: start_marker_r <= cfg_wdata;
        fptcp_pkg::CFG_END_MARKER:   end_marker_r   <= cfg_wdata;
        fptcp_pkg::CFG_SEPARATOR:    separator_r    <= cfg_wdata;
        default: begin
          start_marker_r <= start_marker_r;
        end
      endcase
    end
  end

  // A byte is taken whenever the queue has room for its command.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  fptcp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_marker (start_marker_r),
    .end_marker   (end_marker_r),
    .take         (take),
    .rx_byte      (in_rx_byte),
    .push         (push),
    .cmd          (push_cmd)
  );

  fptcp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  fptcp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .separator        (separator_r),
    .head             (head),
    .empty            (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pan_angle    (out_pan_angle),
    .out_tilt_angle   (out_tilt_angle),
    .out_pan_updated  (out_pan_updated),
    .out_tilt_updated (out_tilt_updated),
    .out_truncated    (out_truncated)
  );

endmodule

[hw/rtl/fptcp_front.sv]
// Front part: frame tracking and byte classification into commands.
// Depends on fptcp_pkg.
module fptcp_front #(
  parameter int unsigned MAX_FRAME_BYTES = fptcp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         start_marker,
  input  logic [7:0]         end_marker,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  output logic               push,
  output fptcp_pkg::cmd_t    cmd
);

  localparam int unsigned CntW    = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned KeepMax = MAX_FRAME_BYTES - 1;

  logic            in_frame_r, in_frame_nxt;
  logic [CntW-1:0] kept_r, kept_nxt;
  logic            ended_r, ended_nxt;
  logic            cut_r, cut_nxt;

  // Classify each transferred byte and update the frame bookkeeping.
  always_comb begin
    in_frame_nxt = in_frame_r;
    kept_nxt     = kept_r;
    ended_nxt    = ended_r;
    cut_nxt      = cut_r;
    push         = 1'b0;
    cmd.kind     = fptcp_pkg::OP_BYTE;
    cmd.data     = rx_byte;
    cmd.cut      = cut_r;
    if (take) begin
      if (!in_frame_r) begin
        if (rx_byte == start_marker) begin
          in_frame_nxt = 1'b1;
          kept_nxt     = '0;
          ended_nxt    = 1'b0;
          cut_nxt      = 1'b0;
        end
      end else if (rx_byte == end_marker) begin
        in_frame_nxt = 1'b0;
        push         = 1'b1;
        cmd.kind     = fptcp_pkg::OP_END;
      end else if (kept_r < CntW'(KeepMax)) begin
        kept_nxt = kept_r + 1'b1;
        if (!ended_r) begin
          push = 1'b1;
          if (rx_byte == fptcp_pkg::CH_NUL) begin
            ended_nxt = 1'b1;
          end
        end
      end else begin
        cut_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      kept_r     <= '0;
      ended_r    <= 1'b0;
      cut_r      <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      kept_r     <= kept_nxt;
      ended_r    <= ended_nxt;
      cut_r      <= cut_nxt;
    end
  end

endmodule

[hw/rtl/fptcp_queue.sv]
// Short command queue between the front and back parts.
// Depends on fptcp_pkg.
module fptcp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fptcp_pkg::cmd_t push_cmd,
  input  logic            pop,
  output fptcp_pkg::cmd_t head,
  output logic            empty,
  output logic            full
);

  localparam int unsigned Depth = fptcp_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  fptcp_pkg::cmd_t slot_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CntW'(Depth));
  assign head  = slot_r[rd_ptr_r];

  // Entry storage; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // The fill count never passes the depth, and the back never reads an empty queue.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("command queue fill count above depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue popped while empty");

endmodule

[hw/rtl/fptcp_back.sv]
// Back part: token conversion, angle registers and the result register.
// Depends on fptcp_pkg.
module fptcp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          separator,
  input  fptcp_pkg::cmd_t     head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_pan_angle,
  output logic signed [15:0]  out_tilt_angle,
  output logic                out_pan_updated,
  output logic                out_tilt_updated,
  output logic                out_truncated
);

  fptcp_pkg::phase_t ph_r, ph_nxt, ph_eff;
  logic [1:0]        idx_r, idx_nxt;
  logic              neg_r, neg_nxt;
  logic [15:0]       mag_r, mag_nxt;
  logic [15:0]       pan_r, pan_nxt, tilt_r, tilt_nxt;
  logic              pan_set_r, pan_set_nxt, tilt_set_r, tilt_set_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_pan_r, out_pan_nxt, out_tilt_r, out_tilt_nxt;
  logic              out_pu_r, out_pu_nxt, out_tu_r, out_tu_nxt, out_cut_r, out_cut_nxt;
  logic              load_out;

  logic              fin_apply, do_fin, closes;
  logic [15:0]       fin_val;
  logic [19:0]       mag_mul;
  logic [15:0]       mag_step;
  logic [7:0]        c;

  assign c = head.data;

  // A result leaves the queue only when the result register can take it.
  assign pop = !empty && ((head.kind == fptcp_pkg::OP_BYTE) || !out_valid_r || out_ready);

  // Value of the current token if it were closed now.
  always_comb begin
    fin_apply = (ph_r != fptcp_pkg::PH_BETWEEN) && (idx_r < fptcp_pkg::TOKENS_USED);
    if (neg_r) begin
      fin_val = 16'd0 - mag_r;
    end else begin
      fin_val = (mag_r > fptcp_pkg::POS_MAX) ? fptcp_pkg::POS_MAX : mag_r;
    end
  end

  // Decimal accumulate step with saturation.
  always_comb begin
    mag_mul  = ({4'd0, mag_r} << 3) + ({4'd0, mag_r} << 1)
             + {12'd0, 4'(c - fptcp_pkg::CH_ZERO)};
    mag_step = (mag_mul > {4'd0, fptcp_pkg::MAG_SAT}) ? fptcp_pkg::MAG_SAT : mag_mul[15:0];
  end

  // Carry out one command.
  always_comb begin
    ph_nxt       = ph_r;
    idx_nxt      = idx_r;
    neg_nxt      = neg_r;
    mag_nxt      = mag_r;
    pan_nxt      = pan_r;
    tilt_nxt     = tilt_r;
    pan_set_nxt  = pan_set_r;
    tilt_set_nxt = tilt_set_r;
    out_pan_nxt  = out_pan_r;
    out_tilt_nxt = out_tilt_r;
    out_pu_nxt   = out_pu_r;
    out_tu_nxt   = out_tu_r;
    out_cut_nxt  = out_cut_r;
    load_out     = 1'b0;
    ph_eff       = (ph_r == fptcp_pkg::PH_BETWEEN) ? fptcp_pkg::PH_SPACE : ph_r;

    closes = (head.kind == fptcp_pkg::OP_END) || (c == fptcp_pkg::CH_NUL) || (c == separator);
    do_fin = pop && closes && fin_apply;

    // Close the current token into its angle.
    if (do_fin) begin
      if (idx_r == 2'd0) begin
        pan_nxt     = fin_val;
        pan_set_nxt = 1'b1;
      end else begin
        tilt_nxt     = fin_val;
        tilt_set_nxt = 1'b1;
      end
      idx_nxt = idx_r + 1'b1;
      ph_nxt  = fptcp_pkg::PH_BETWEEN;
      neg_nxt = 1'b0;
      mag_nxt = '0;
    end

    if (pop) begin
      case (head.kind)
        fptcp_pkg::OP_END: begin
          load_out     = 1'b1;
          out_pan_nxt  = pan_nxt;
          out_tilt_nxt = tilt_nxt;
          out_pu_nxt   = pan_set_nxt;
          out_tu_nxt   = tilt_set_nxt;
          out_cut_nxt  = head.cut;
          // The next frame starts from a clean token state.
          idx_nxt      = '0;
          ph_nxt       = fptcp_pkg::PH_BETWEEN;
          neg_nxt      = 1'b0;
          mag_nxt      = '0;
          pan_set_nxt  = 1'b0;
          tilt_set_nxt = 1'b0;
        end
        fptcp_pkg::OP_BYTE: begin
          if (!closes && (idx_r < fptcp_pkg::TOKENS_USED)) begin
            case (ph_eff)
              fptcp_pkg::PH_SPACE: begin
                ph_nxt = ph_eff;
                if (fptcp_pkg::is_space(c)) begin
                  ph_nxt = fptcp_pkg::PH_SPACE;
                end else if ((c == fptcp_pkg::CH_PLUS) || (c == fptcp_pkg::CH_MINUS)) begin
                  neg_nxt = (c == fptcp_pkg::CH_MINUS);
                  ph_nxt  = fptcp_pkg::PH_SIGN;
                end else if (!fptcp_pkg::is_digit(c)) begin
                  ph_nxt = fptcp_pkg::PH_DONE;
                end else begin
                  ph_nxt  = fptcp_pkg::PH_DIGITS;
                  mag_nxt = {12'd0, 4'(c - fptcp_pkg::CH_ZERO)};
                end
              end
              fptcp_pkg::PH_SIGN, fptcp_pkg::PH_DIGITS: begin
                if (!fptcp_pkg::is_digit(c)) begin
                  ph_nxt = fptcp_pkg::PH_DONE;
                end else begin
                  ph_nxt  = fptcp_pkg::PH_DIGITS;
                  mag_nxt = mag_step;
                end
              end
              default: begin
                ph_nxt = ph_r;
              end
            endcase
          end
        end
        default: begin
          load_out = 1'b0;
        end
      endcase
    end

    // Result register: held until the downstream side takes it.
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= fptcp_pkg::PH_BETWEEN;
      idx_r       <= '0;
      neg_r       <= 1'b0;
      mag_r       <= '0;
      pan_r       <= fptcp_pkg::PAN_RST;
      tilt_r      <= fptcp_pkg::TILT_RST;
      pan_set_r   <= 1'b0;
      tilt_set_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      idx_r       <= idx_nxt;
      neg_r       <= neg_nxt;
      mag_r       <= mag_nxt;
      pan_r       <= pan_nxt;
      tilt_r      <= tilt_nxt;
      pan_set_r   <= pan_set_nxt;
      tilt_set_r  <= tilt_set_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_pan_r  <= out_pan_nxt;
    out_tilt_r <= out_tilt_nxt;
    out_pu_r   <= out_pu_nxt;
    out_tu_r   <= out_tu_nxt;
    out_cut_r  <= out_cut_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pan_angle    = out_pan_r;
  assign out_tilt_angle   = out_tilt_r;
  assign out_pan_updated  = out_pu_r;
  assign out_tilt_updated = out_tu_r;
  assign out_truncated    = out_cut_r;

  // An end command always shows up as a result in the next cycle.
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (head.kind == fptcp_pkg::OP_END)) |=> out_valid)
    else $error("end command did not produce a result");
  // Once both tokens are taken, no further token is opened.
  a_idle_after_two: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r == fptcp_pkg::TOKENS_USED) |-> (ph_r == fptcp_pkg::PH_BETWEEN))
    else $error("token opened after the second one");
  // The magnitude never passes its saturation point, and the token index never passes the tokens used.
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mag_r <= fptcp_pkg::MAG_SAT) && (idx_r <= fptcp_pkg::TOKENS_USED))
    else $error("token magnitude or index out of range");

endmodule
